FILE: src/pixel_gain_offset_energy_calibrator_top_macros.svh
// Assertion macros shared by the calibrator checker.
`ifndef PIXEL_GAIN_OFFSET_ENERGY_CALIBRATOR_TOP_MACROS_SVH
`define PIXEL_GAIN_OFFSET_ENERGY_CALIBRATOR_TOP_MACROS_SVH

// Check a property on every edge outside reset.
`define PGOE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pgoe assertion failed");

// Check a property on every edge, reset included.
`define PGOE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pgoe assertion failed");

`endif

FILE: src/pgoe_pkg.sv
// Shared types and constants of the pixel calibrator.
`timescale 1ns / 1ps

package pgoe_pkg;

  typedef enum logic [1:0] {
    OP_EVENT  = 2'd0,
    OP_GAIN   = 2'd1,
    OP_OFFSET = 2'd2,
    OP_ENERGY = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    QUAD_LL = 2'd0,
    QUAD_LR = 2'd1,
    QUAD_UR = 2'd2,
    QUAD_UL = 2'd3
  } quadrant_t;

  // Classified request as it travels from the front end to the back end.
  typedef struct packed {
    opcode_t     kind;
    logic [11:0] pha;
    logic        last;
    logic [15:0] data;
  } cmd_t;

  localparam int QUEUE_DEPTH = 4;

  // Products at or below this value truncate to a nonzero negative PI.
  localparam logic signed [34:0] NEG_LIMIT = -35'sd262144;

endpackage

FILE: src/pgoe_if.sv
// Request and result channel interfaces of the pixel calibrator.
`timescale 1ns / 1ps

interface pgoe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [1:0]  quadrant;
  logic [5:0]  local_x;
  logic [5:0]  local_y;
  logic [11:0] pulse_height;
  logic [13:0] table_index;
  logic [15:0] load_word;
  logic [15:0] load_upper;
  logic        last_in;

  modport source (
    output valid, opcode, quadrant, local_x, local_y, pulse_height,
    output table_index, load_word, load_upper, last_in,
    input  ready
  );
  modport sink (
    input  valid, opcode, quadrant, local_x, local_y, pulse_height,
    input  table_index, load_word, load_upper, last_in,
    output ready
  );
endinterface

interface pgoe_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pi_code;
  logic [15:0] energy_code;
  logic        clamped;
  logic        last_out;

  modport source (
    output valid, pi_code, energy_code, clamped, last_out,
    input  ready
  );
  modport sink (
    input  valid, pi_code, energy_code, clamped, last_out,
    output ready
  );
endinterface

FILE: src/pixel_gain_offset_energy_calibrator_top.sv
// Top level of the per-pixel gain, offset and energy calibrator.
`timescale 1ns / 1ps

// Takes one request per clock. Load requests write the gain, offset or energy
// table and give no result; an event request gives one result after it passes
// the request queue, the gain and offset table read, the offset subtract, the
// gain multiply, and the result register that also reads the energy table.
// Results leave in request order at one per cycle while each is taken. A
// four-entry queue lets requests keep coming while a result waits to be taken;
// the input stalls only once that queue fills. Tables hold nothing useful after
// reset and must be loaded before an event reads them; no clearing pass runs.
module pixel_gain_offset_energy_calibrator_top import pgoe_pkg::*; #(
  parameter int DET_WIDTH  = 128,
  parameter int DET_HEIGHT = 128,
  parameter int CHANNELS   = 512
) (
  input  logic clk,
  input  logic rst,
  pgoe_in_if.sink     events,
  pgoe_out_if.source  results
);

  localparam int PW = $clog2(DET_WIDTH * DET_HEIGHT);
  localparam int CW = $clog2(CHANNELS);
  localparam int AW = (PW > CW) ? PW : CW;
  localparam int QW = $bits(cmd_t) + AW;

  logic          queue_ready;
  logic          push;
  cmd_t          push_cmd;
  logic [AW-1:0] push_addr;
  logic          pop;
  logic          head_valid;
  logic [QW-1:0] head_data;
  cmd_t          head_cmd;
  logic [AW-1:0] head_addr;

  pgoe_front #(
    .DET_WIDTH  (DET_WIDTH),
    .DET_HEIGHT (DET_HEIGHT),
    .CHANNELS   (CHANNELS)
  ) u_front (
    .events      (events),
    .queue_ready (queue_ready),
    .push        (push),
    .cmd         (push_cmd),
    .addr        (push_addr)
  );

  pgoe_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({push_cmd, push_addr}),
    .ready      (queue_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign head_cmd  = head_data[QW-1:AW];
  assign head_addr = head_data[AW-1:0];

  pgoe_back #(
    .DET_WIDTH  (DET_WIDTH),
    .DET_HEIGHT (DET_HEIGHT),
    .CHANNELS   (CHANNELS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .head_addr  (head_addr),
    .pop        (pop),
    .results    (results)
  );

endmodule

FILE: src/pgoe_front.sv
// Front end: accepts requests, places event pixels on the detector, checks loads.
`timescale 1ns / 1ps

module pgoe_front import pgoe_pkg::*; #(
  parameter int DET_WIDTH  = 128,
  parameter int DET_HEIGHT = 128,
  parameter int CHANNELS   = 512
) (
  pgoe_in_if.sink events,
  input  logic    queue_ready,
  output logic    push,
  output cmd_t    cmd,
  output logic [((($clog2(DET_WIDTH * DET_HEIGHT)) > ($clog2(CHANNELS)))
                 ? $clog2(DET_WIDTH * DET_HEIGHT) : $clog2(CHANNELS)) - 1:0] addr
);

  localparam int PIX_COUNT = DET_WIDTH * DET_HEIGHT;
  localparam int PW  = $clog2(PIX_COUNT);
  localparam int CW  = $clog2(CHANNELS);
  localparam int AW  = (PW > CW) ? PW : CW;
  localparam int XSW = $clog2(DET_WIDTH + 64);
  localparam int YSW = $clog2(DET_HEIGHT + 64);
  localparam int XW  = $clog2(DET_WIDTH);
  localparam int YW  = $clog2(DET_HEIGHT);

  quadrant_t       quad;
  opcode_t         op;
  logic [XSW-1:0]  x_sum;
  logic [YSW-1:0]  y_sum;
  logic [XW-1:0]   det_x;
  logic [YW-1:0]   det_y;
  logic [PW-1:0]   pix;
  logic [16:0]     bound_sum;
  logic            keep;

  assign quad = quadrant_t'(events.quadrant);
  assign op   = opcode_t'(events.opcode);

  always_comb begin
    x_sum = XSW'(events.local_x);
    y_sum = YSW'(events.local_y);
    if (quad == QUAD_LR || quad == QUAD_UR) begin
      x_sum = x_sum + XSW'(DET_WIDTH / 2);
    end
    if (quad == QUAD_UR || quad == QUAD_UL) begin
      y_sum = y_sum + YSW'(DET_HEIGHT / 2);
    end
    // Clip coordinates that run past the detector edge.
    det_x = (x_sum > XSW'(DET_WIDTH - 1)) ? XW'(DET_WIDTH - 1) : x_sum[XW-1:0];
    det_y = (y_sum > YSW'(DET_HEIGHT - 1)) ? YW'(DET_HEIGHT - 1) : y_sum[YW-1:0];
    pix   = PW'(det_y) * PW'(DET_WIDTH) + PW'(det_x);
  end

  assign bound_sum = {1'b0, events.load_word} + {1'b0, events.load_upper};

  always_comb begin
    cmd.kind = op;
    cmd.pha  = events.pulse_height;
    cmd.last = events.last_in;
    cmd.data = events.load_word;
    addr     = AW'(events.table_index);
    keep     = 1'b0;
    unique case (op)
      OP_EVENT: begin
        keep = 1'b1;
        addr = AW'(pix);
      end
      OP_GAIN, OP_OFFSET: begin
        keep = 32'(events.table_index) < PIX_COUNT;
      end
      OP_ENERGY: begin
        keep     = 32'(events.table_index) < CHANNELS;
        cmd.data = bound_sum[16:1];
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Drop out-of-range loads here; they are still accepted.
  assign events.ready = queue_ready;
  assign push         = events.valid && queue_ready && keep;

endmodule

FILE: src/pgoe_queue.sv
// Short queue between the front end and the back end.
`timescale 1ns / 1ps

module pgoe_queue import pgoe_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             ready,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTRW = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entries [QUEUE_DEPTH];
  logic [PTRW-1:0]  wr_ptr;
  logic [PTRW-1:0]  rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_pop;

  assign ready      = count != CNTW'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_data  = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/pgoe_back.sv
// Back end: table stores, calibration pipeline and result register.
`timescale 1ns / 1ps

module pgoe_back import pgoe_pkg::*; #(
  parameter int DET_WIDTH  = 128,
  parameter int DET_HEIGHT = 128,
  parameter int CHANNELS   = 512
) (
  input  logic clk,
  input  logic rst,
  input  logic head_valid,
  input  cmd_t head_cmd,
  input  logic [((($clog2(DET_WIDTH * DET_HEIGHT)) > ($clog2(CHANNELS)))
                 ? $clog2(DET_WIDTH * DET_HEIGHT) : $clog2(CHANNELS)) - 1:0] head_addr,
  output logic pop,
  pgoe_out_if.source results
);

  localparam int PIX_COUNT = DET_WIDTH * DET_HEIGHT;
  localparam int PW = $clog2(PIX_COUNT);
  localparam int CW = $clog2(CHANNELS);
  localparam int AW = (PW > CW) ? PW : CW;

  logic [15:0] gain_mem   [PIX_COUNT];
  logic [15:0] offset_mem [PIX_COUNT];
  logic [15:0] energy_mem [CHANNELS];

  logic               adv;
  logic               s1_valid, s2_valid, s3_valid;
  cmd_t               s1_cmd, s2_cmd, s3_cmd;
  logic [AW-1:0]      s1_addr, s2_addr, s3_addr;
  logic [15:0]        gain_rd, offset_rd;
  logic signed [17:0] s2_diff;
  logic [15:0]        s2_gain;
  logic signed [34:0] s3_prod;

  logic               res_valid;
  logic [15:0]        res_pi;
  logic [15:0]        res_energy;
  logic               res_clamped;
  logic               res_last;

  logic [15:0]        pi;
  logic               neg_flag;
  logic               chan_clamp;
  logic [CW-1:0]      chan;

  // Whole pipeline moves when the result register is free or being taken.
  assign adv = !res_valid || results.ready;
  assign pop = adv;

  // Stage 1: pixel table access, writes and reads in request order.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (head_valid && head_cmd.kind == OP_GAIN) begin
        gain_mem[head_addr[PW-1:0]] <= head_cmd.data;
      end
      gain_rd <= gain_mem[head_addr[PW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (head_valid && head_cmd.kind == OP_OFFSET) begin
        offset_mem[head_addr[PW-1:0]] <= head_cmd.data;
      end
      offset_rd <= offset_mem[head_addr[PW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd  <= head_cmd;
      s1_addr <= head_addr;
      // Stage 2: pulse height in Q.4 minus signed offset.
      s2_cmd  <= s1_cmd;
      s2_addr <= s1_addr;
      s2_gain <= gain_rd;
      s2_diff <= {2'b00, s1_cmd.pha, 4'b0000} - {{2{offset_rd[15]}}, offset_rd};
      // Stage 3: signed Q.18 product.
      s3_cmd  <= s2_cmd;
      s3_addr <= s2_addr;
      s3_prod <= 35'(s2_diff) * 35'($signed({1'b0, s2_gain}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= head_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      res_valid <= s3_valid && s3_cmd.kind == OP_EVENT;
    end
  end

  // A 35-bit product shifted by 18 always fits 16 bits, so only the low end saturates.
  always_comb begin
    pi         = s3_prod[34] ? 16'd0 : s3_prod[33:18];
    neg_flag   = s3_prod <= NEG_LIMIT;
    chan_clamp = pi > 16'(CHANNELS - 1);
    chan       = chan_clamp ? CW'(CHANNELS - 1) : pi[CW-1:0];
  end

  // Result stage: energy table shares this stage with its loads to keep order.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (s3_valid && s3_cmd.kind == OP_ENERGY) begin
        energy_mem[s3_addr[CW-1:0]] <= s3_cmd.data;
      end
      res_energy  <= energy_mem[chan];
      res_pi      <= pi;
      res_clamped <= neg_flag || chan_clamp;
      res_last    <= s3_cmd.last;
    end
  end

  assign results.valid       = res_valid;
  assign results.pi_code     = res_pi;
  assign results.energy_code = res_energy;
  assign results.clamped     = res_clamped;
  assign results.last_out    = res_last;

endmodule

FILE: src/pgoe_checker.sv
// Port-level checker for the calibrator and its bind to the top level.
`timescale 1ns / 1ps
`include "pixel_gain_offset_energy_calibrator_top_macros.svh"

module pgoe_checker #(
  parameter int CHANNELS = 512
) (
  input logic clk,
  input logic rst,
  pgoe_in_if.sink    events,
  pgoe_out_if.source results
);

  // Reset empties the result register.
  `PGOE_ASSERT_ALWAYS(a_reset_clears, rst |=> !results.valid)

  // No result can leave after reset before a request has passed every pipeline register.
  `PGOE_ASSERT(a_min_latency, $fell(rst) |-> !results.valid ##1 !results.valid ##1 !results.valid ##1 !results.valid)

  // The queue is empty after reset, so requests are taken at once.
  `PGOE_ASSERT(a_ready_after_reset, $fell(rst) |-> events.ready)

  // A channel beyond the energy table must be flagged.
  `PGOE_ASSERT(a_clamp_flag, results.valid && (results.pi_code > 16'(CHANNELS - 1)) |-> results.clamped)

  // Hold a stalled result.
  `PGOE_ASSERT(a_result_hold, results.valid && !results.ready |=> results.valid && $stable(results.pi_code) && $stable(results.energy_code))

endmodule

bind pixel_gain_offset_energy_calibrator_top pgoe_checker #(
  .CHANNELS (CHANNELS)
) u_pgoe_checker (
  .clk     (clk),
  .rst     (rst),
  .events  (events),
  .results (results)
);
